FILE: hdl/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg
// shared types and character codes for the tape-language execute unit
// ----------------------------------------------------------------------------
`default_nettype none

package bfe_pkg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_OUT  = 2'd1,
        KIND_JUMP = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_PUT   = 8'h2E;
    localparam logic [7:0] CH_GET   = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int          SKIP_W   = 11;
    localparam logic [10:0] SKIP_MAX = 11'd2047;

endpackage

`default_nettype wire

FILE: hdl/bfe_cmd_if.sv
// ----------------------------------------------------------------------------
// bfe_cmd_if
// program character channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bfe_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  code_byte;
    logic [15:0] code_pos;
    logic [7:0]  in_byte;

    modport source (output valid, output code_byte, output code_pos, output in_byte,
                    input ready);
    modport sink   (input valid, input code_byte, input code_pos, input in_byte,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/bfe_res_if.sv
// ----------------------------------------------------------------------------
// bfe_res_if
// result channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bfe_res_if import bfe_pkg::*; ();
    logic        valid;
    logic        ready;
    kind_t       result_kind;
    logic [7:0]  out_byte;
    logic [15:0] jump_target;

    modport source (output valid, output result_kind, output out_byte,
                    output jump_target, input ready);
    modport sink   (input valid, input result_kind, input out_byte,
                    input jump_target, output ready);
endinterface

`default_nettype wire

FILE: hdl/bfe_ram.sv
// ----------------------------------------------------------------------------
// bfe_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bfe_tape.sv
// ----------------------------------------------------------------------------
// bfe_tape
// tape memory with clearing sweep after reset and last-write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module bfe_tape #(
    parameter int TAPE_DEPTH = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(TAPE_DEPTH)-1:0] rd_addr,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(TAPE_DEPTH)-1:0] wr_addr,
    input  wire logic [7:0]                    wr_data,
    output logic      [7:0]                    rd_data,
    output logic                               busy
);

    localparam int AW = $clog2(TAPE_DEPTH);

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // one cell a cycle is zeroed after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(TAPE_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // a write at the same edge as the read would be missed by the ram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign ram_we    = clr_busy_reg || wr_en;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign ram_wdata = clr_busy_reg ? 8'd0 : wr_data;

    bfe_ram #(
        .WIDTH (8),
        .DEPTH (TAPE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign rd_data = fwd_reg ? fwd_data_reg : ram_rdata;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

FILE: hdl/bfe_stack.sv
// ----------------------------------------------------------------------------
// bfe_stack
// loop-start stack memory, top entry read ahead with push forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module bfe_stack #(
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
    input  wire logic [15:0]                    wr_data,
    output logic      [15:0]                    top
);

    logic        fwd_reg;
    logic [15:0] fwd_data_reg;
    logic [15:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    bfe_ram #(
        .WIDTH (16),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign top = fwd_reg ? fwd_data_reg : ram_rdata;

endmodule

`default_nettype wire

FILE: hdl/bf_execute_unit.sv
// ----------------------------------------------------------------------------
// bf_execute_unit
// execute unit for the eight-command tape language
// ----------------------------------------------------------------------------
// Takes one program character per cycle while cmd.ready is high and gives
// exactly one result per character. Each character is a read-modify-write of
// the tape ram and the loop stack ram: the cell under the data pointer and the
// stack top are read at acceptance and used and written back as the character
// leaves the execute stage, with the last write forwarded so that consecutive
// characters on the same cell run without a gap. After reset all TAPE_DEPTH
// tape cells (65536 by default) are cleared one cell a cycle; cmd.ready stays
// low until the sweep is done. A stack error halts the unit until reset; later
// characters each give a "nothing" result.
`default_nettype none

module bf_execute_unit
    import bfe_pkg::*;
#(
    parameter int TAPE_DEPTH  = 65536,
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bfe_cmd_if.sink     cmd,
    bfe_res_if.source   res
);

    localparam int AW  = $clog2(TAPE_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);

    // control state
    logic [AW-1:0]     dp_reg, dp_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic              slash_reg, slash_next;
    logic              comment_reg, comment_next;
    logic              halted_reg, halted_next;

    // execute stage
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic [15:0]       s1_pos_reg;
    logic [7:0]        s1_in_reg;
    logic              s1_fire;

    // output register
    logic              res_valid_reg;
    kind_t             kind_reg, kind_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic [15:0]       target_reg, target_next;

    // memory side
    logic              tape_busy;
    logic [7:0]        cell_val;
    logic              tape_we;
    logic [7:0]        tape_wdata;
    logic [AW-1:0]     tape_raddr;
    logic [15:0]       stk_top;
    logic              stk_we;
    logic [CW-1:0]     cnt_sel;
    logic [CW-1:0]     cnt_dec;
    logic              cmd_fire;

    assign s1_fire   = s1_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !tape_busy && (!s1_valid_reg || s1_fire);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // next item reads at the state this one leaves behind
    assign tape_raddr = s1_fire ? dp_next : dp_reg;
    assign cnt_sel    = s1_fire ? cnt_next : cnt_reg;
    assign cnt_dec    = cnt_sel - 1'b1;

    always_comb
    begin
        dp_next      = dp_reg;
        cnt_next     = cnt_reg;
        skip_next    = skip_reg;
        slash_next   = slash_reg;
        comment_next = comment_reg;
        halted_next  = halted_reg;
        kind_next    = KIND_NONE;
        obyte_next   = 8'd0;
        target_next  = 16'd0;
        tape_we      = 1'b0;
        tape_wdata   = cell_val;
        stk_we       = 1'b0;

        if (halted_reg)
        begin
            // everything ignored until reset
        end
        else if (comment_reg)
        begin
            if (s1_byte_reg == CH_NL)
            begin
                comment_next = 1'b0;
            end
        end
        else if (s1_byte_reg == CH_SLASH)
        begin
            slash_next   = !slash_reg;
            comment_next = slash_reg;
        end
        else if (skip_reg != '0)
        begin
            if (s1_byte_reg == CH_OPEN)
            begin
                if (skip_reg != SKIP_MAX)
                begin
                    skip_next = skip_reg + 1'b1;
                end
            end
            else if (s1_byte_reg == CH_CLOSE)
            begin
                skip_next = skip_reg - 1'b1;
            end
        end
        else
        begin
            case (s1_byte_reg)
                CH_RIGHT:
                begin
                    dp_next = (dp_reg == AW'(TAPE_DEPTH - 1)) ? '0 : dp_reg + 1'b1;
                end
                CH_LEFT:
                begin
                    dp_next = (dp_reg == '0) ? AW'(TAPE_DEPTH - 1) : dp_reg - 1'b1;
                end
                CH_INC:
                begin
                    tape_we    = 1'b1;
                    tape_wdata = cell_val + 8'd1;
                end
                CH_DEC:
                begin
                    tape_we    = 1'b1;
                    tape_wdata = cell_val - 8'd1;
                end
                CH_PUT:
                begin
                    kind_next  = KIND_OUT;
                    obyte_next = cell_val;
                end
                CH_GET:
                begin
                    tape_we    = 1'b1;
                    tape_wdata = s1_in_reg;
                end
                CH_OPEN:
                begin
                    if (cell_val == 8'd0)
                    begin
                        skip_next = SKIP_W'(1);
                    end
                    else if (cnt_reg == CW'(STACK_DEPTH))
                    begin
                        halted_next = 1'b1;
                        kind_next   = KIND_ERR;
                        target_next = s1_pos_reg;
                    end
                    else
                    begin
                        stk_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                CH_CLOSE:
                begin
                    if (cnt_reg == '0)
                    begin
                        halted_next = 1'b1;
                        kind_next   = KIND_ERR;
                        target_next = s1_pos_reg;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        if (cell_val != 8'd0)
                        begin
                            kind_next   = KIND_JUMP;
                            target_next = stk_top;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg      <= '0;
            cnt_reg     <= '0;
            skip_reg    <= '0;
            slash_reg   <= 1'b0;
            comment_reg <= 1'b0;
            halted_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            dp_reg      <= dp_next;
            cnt_reg     <= cnt_next;
            skip_reg    <= skip_next;
            slash_reg   <= slash_next;
            comment_reg <= comment_next;
            halted_reg  <= halted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_byte_reg <= cmd.code_byte;
            s1_pos_reg  <= cmd.code_pos;
            s1_in_reg   <= cmd.in_byte;
        end
        if (s1_fire)
        begin
            kind_reg   <= kind_next;
            obyte_reg  <= obyte_next;
            target_reg <= target_next;
        end
    end

    bfe_tape #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_tape (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cmd_fire),
        .rd_addr (tape_raddr),
        .wr_en   (tape_we && s1_fire),
        .wr_addr (dp_reg),
        .wr_data (tape_wdata),
        .rd_data (cell_val),
        .busy    (tape_busy)
    );

    bfe_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cmd_fire),
        .rd_addr (cnt_dec[SAW-1:0]),
        .wr_en   (stk_we && s1_fire),
        .wr_addr (cnt_reg[SAW-1:0]),
        .wr_data (s1_pos_reg),
        .top     (stk_top)
    );

    assign res.valid       = res_valid_reg;
    assign res.result_kind = kind_reg;
    assign res.out_byte    = obyte_reg;
    assign res.jump_target = target_reg;

endmodule

`default_nettype wire

FILE: hdl/bfe_checker.sv
// ----------------------------------------------------------------------------
// bfe_checker
// port-level checks on the execute unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bfe_checker
    import bfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    input  wire logic        cmd_ready,
    input  wire logic        res_valid,
    input  wire logic        res_ready,
    input  wire kind_t       result_kind,
    input  wire logic [7:0]  out_byte,
    input  wire logic [15:0] jump_target
);

    // a stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind)
            && $stable(out_byte) && $stable(jump_target))
        else $error("result changed while stalled");

    // output byte only carries data on an output result
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind != KIND_OUT |-> out_byte == 8'd0)
        else $error("out_byte nonzero outside an output result");

    // target only carries data on a jump or an error
    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (result_kind == KIND_NONE || result_kind == KIND_OUT)
            |-> jump_target == 16'd0)
        else $error("jump_target nonzero on a plain result");

    // a result only rises after a command transaction has passed the execute stage
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("result appeared with no command");

endmodule

bind bf_execute_unit bfe_checker u_bfe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .result_kind (res.result_kind),
    .out_byte    (res.out_byte),
    .jump_target (res.jump_target)
);

`default_nettype wire
